// ----- rtl/core/tun_pkg.sv -----
`default_nettype none
package tun_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int LANES          = 3;
    localparam int NORM_BITS      = 16;
    // |c| * 2^15 / sqrt(S), squared: c^2 * 2^30 against q^2 * S
    localparam int FRAC_SHIFT     = 2 * (NORM_BITS - 1);
    localparam logic [NORM_BITS-1:0] NORM_MAX = {1'b0, {(NORM_BITS-1){1'b1}}};

endpackage
`default_nettype wire

// ----- rtl/core/tun_cross.sv -----
`default_nettype none
module tun_cross #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [9*COORD_BITS-1:0]       in_vtx,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [2*COORD_BITS+1:0]     out_c [tun_pkg::LANES]
);
    localparam int EW = COORD_BITS + 1;
    localparam int XW = 2 * EW;

    logic signed [COORD_BITS-1:0] vtx [9];
    logic signed [EW-1:0]         ea_reg [3];
    logic signed [EW-1:0]         eb_reg [3];
    logic signed [XW-1:0]         pr_reg [6];
    logic signed [XW-1:0]         c_reg  [3];
    logic [2:0]                   v_reg;
    logic [2:0]                   en;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            vtx[i] = in_vtx[i*COORD_BITS +: COORD_BITS];
        end
    end

    assign en[2]    = !v_reg[2] || out_ready;
    assign en[1]    = !v_reg[1] || en[2];
    assign en[0]    = !v_reg[0] || en[1];
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    // edges, then the six products, then the cross differences
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                ea_reg[i] <= EW'(vtx[3+i]) - EW'(vtx[i]);
                eb_reg[i] <= EW'(vtx[6+i]) - EW'(vtx[i]);
            end
        end
        if (en[1])
        begin
            pr_reg[0] <= XW'(ea_reg[1]) * XW'(eb_reg[2]);
            pr_reg[1] <= XW'(ea_reg[2]) * XW'(eb_reg[1]);
            pr_reg[2] <= XW'(ea_reg[2]) * XW'(eb_reg[0]);
            pr_reg[3] <= XW'(ea_reg[0]) * XW'(eb_reg[2]);
            pr_reg[4] <= XW'(ea_reg[0]) * XW'(eb_reg[1]);
            pr_reg[5] <= XW'(ea_reg[1]) * XW'(eb_reg[0]);
        end
        if (en[2])
        begin
            c_reg[0] <= pr_reg[0] - pr_reg[1];
            c_reg[1] <= pr_reg[2] - pr_reg[3];
            c_reg[2] <= pr_reg[4] - pr_reg[5];
        end
    end

    assign out_valid = v_reg[2];
    assign out_c     = c_reg;

endmodule
`default_nettype wire

// ----- rtl/core/tun_square.sv -----
`default_nettype none
module tun_square #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [2*COORD_BITS+1:0] in_c [tun_pkg::LANES],
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [4*COORD_BITS+1:0]            out_m2 [tun_pkg::LANES],
    output logic [4*COORD_BITS+3:0]            out_s,
    output logic [tun_pkg::LANES-1:0]          out_neg,
    output logic                               out_degen
);
    localparam int XW  = 2 * COORD_BITS + 2;
    localparam int MW  = 2 * COORD_BITS + 1;
    localparam int LW  = (MW + 1) / 2;
    localparam int HW  = MW - LW;
    localparam int M2W = 2 * MW;
    localparam int SW  = M2W + 2;
    localparam int NL  = tun_pkg::LANES;

    logic [MW-1:0]     mabs [NL];
    logic [2*HW-1:0]   hh_reg [NL];
    logic [MW-1:0]     hl_reg [NL];
    logic [2*LW-1:0]   ll_reg [NL];
    logic [NL-1:0]     neg1_reg, neg2_reg, neg3_reg;
    logic [M2W-1:0]    m2_reg  [NL];
    logic [M2W-1:0]    m2o_reg [NL];
    logic [SW-1:0]     s_reg;
    logic              degen_reg;
    logic [2:0]        v_reg;
    logic [2:0]        en;

    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            mabs[i] = in_c[i][XW-1] ? MW'(-in_c[i]) : MW'(in_c[i]);
        end
    end

    assign en[2]    = !v_reg[2] || out_ready;
    assign en[1]    = !v_reg[1] || en[2];
    assign en[0]    = !v_reg[0] || en[1];
    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (en[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    // square each magnitude from half-width partial products
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int i = 0; i < NL; i++)
            begin
                hh_reg[i]   <= (2*HW)'(mabs[i][MW-1:LW]) * (2*HW)'(mabs[i][MW-1:LW]);
                hl_reg[i]   <= MW'(mabs[i][MW-1:LW]) * MW'(mabs[i][LW-1:0]);
                ll_reg[i]   <= (2*LW)'(mabs[i][LW-1:0]) * (2*LW)'(mabs[i][LW-1:0]);
                neg1_reg[i] <= in_c[i][XW-1];
            end
        end
        if (en[1])
        begin
            for (int i = 0; i < NL; i++)
            begin
                m2_reg[i] <= (M2W'(hh_reg[i]) << (2*LW)) + (M2W'(hl_reg[i]) << (LW+1))
                             + M2W'(ll_reg[i]);
            end
            neg2_reg <= neg1_reg;
        end
        if (en[2])
        begin
            s_reg     <= SW'(m2_reg[0]) + SW'(m2_reg[1]) + SW'(m2_reg[2]);
            degen_reg <= ((m2_reg[0] | m2_reg[1] | m2_reg[2]) == '0);
            m2o_reg   <= m2_reg;
            neg3_reg  <= neg2_reg;
        end
    end

    assign out_valid = v_reg[2];
    assign out_m2    = m2o_reg;
    assign out_s     = s_reg;
    assign out_neg   = neg3_reg;
    assign out_degen = degen_reg;

endmodule
`default_nettype wire

// ----- rtl/core/tun_root_step.sv -----
`default_nettype none
module tun_root_step #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF,
    parameter int BIT        = 15
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [4*COORD_BITS+1+tun_pkg::FRAC_SHIFT:0] in_r [tun_pkg::LANES],
    input  wire logic [4*COORD_BITS+3+tun_pkg::NORM_BITS:0]  in_qs [tun_pkg::LANES],
    input  wire logic [tun_pkg::NORM_BITS-1:0]         in_q [tun_pkg::LANES],
    input  wire logic [4*COORD_BITS+3:0]               in_s,
    input  wire logic [tun_pkg::LANES-1:0]             in_neg,
    input  wire logic                                  in_degen,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic [4*COORD_BITS+1+tun_pkg::FRAC_SHIFT:0] out_r [tun_pkg::LANES],
    output logic [4*COORD_BITS+3+tun_pkg::NORM_BITS:0]  out_qs [tun_pkg::LANES],
    output logic [tun_pkg::NORM_BITS-1:0]              out_q [tun_pkg::LANES],
    output logic [4*COORD_BITS+3:0]                    out_s,
    output logic [tun_pkg::LANES-1:0]                  out_neg,
    output logic                                       out_degen
);
    localparam int QB  = tun_pkg::NORM_BITS;
    localparam int SW  = 4 * COORD_BITS + 4;
    localparam int RW  = 4 * COORD_BITS + 2 + tun_pkg::FRAC_SHIFT;
    localparam int QSW = SW + QB;
    localparam int DW  = QSW + QB + 1;
    localparam int NL  = tun_pkg::LANES;

    logic [DW-1:0]  delta [NL];
    logic [DW-1:0]  diff  [NL];
    logic [NL-1:0]  take;
    logic [RW-1:0]  r_reg  [NL];
    logic [QSW-1:0] qs_reg [NL];
    logic [QB-1:0]  q_reg  [NL];
    logic [SW-1:0]  s_reg;
    logic [NL-1:0]  neg_reg;
    logic           degen_reg;
    logic           v_reg;
    logic           en;

    // (q + 2^b)^2 * S - q^2 * S = (q*S << b+1) + (S << 2b)
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            delta[i] = (DW'(in_qs[i]) << (BIT + 1)) + (DW'(in_s) << (2 * BIT));
            diff[i]  = DW'(in_r[i]) - delta[i];
            take[i]  = DW'(in_r[i]) >= delta[i];
        end
    end

    assign en       = !v_reg || out_ready;
    assign in_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < NL; i++)
            begin
                r_reg[i]  <= take[i] ? RW'(diff[i]) : in_r[i];
                qs_reg[i] <= take[i] ? in_qs[i] + (QSW'(in_s) << BIT) : in_qs[i];
                q_reg[i]  <= take[i] ? (in_q[i] | (QB'(1) << BIT)) : in_q[i];
            end
            s_reg     <= in_s;
            neg_reg   <= in_neg;
            degen_reg <= in_degen;
        end
    end

    assign out_valid = v_reg;
    assign out_r     = r_reg;
    assign out_qs    = qs_reg;
    assign out_q     = q_reg;
    assign out_s     = s_reg;
    assign out_neg   = neg_reg;
    assign out_degen = degen_reg;

endmodule
`default_nettype wire

// ----- rtl/core/triangle_unit_normal.sv -----
// Unit normal of a triangle, Q1.15 components.
//
// Slave channel: one beat carries the nine vertex coordinates v0..v2 (x,y,z).
// Master channel: one beat carries norm_x/y/z in tdata and the degenerate
// flag in tuser. Each component is sign(c)*floor(|c|*2^15/|c_vec|) with the
// positive full-scale value held at 32767; a zero cross product gives zero
// components and degenerate set.
//
// The pipeline runs through the edge and cross-product registers, the magnitude,
// square and sum registers, the square-root search (one quotient bit per
// stage, three lanes side by side) and the output register.
// Throughput is one beat per cycle while m_tready stays high; every stage carries its own valid bit
// and moves whenever the stage after it is empty or moving.
//
// Reset clears only the valid bits. When the receiver holds off tready the
// pipeline keeps filling its empty stages and then backs up to s_tready;
// no beat is dropped or repeated.
`default_nettype none
module triangle_unit_normal #(
    parameter int COORD_BITS = tun_pkg::COORD_BITS_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, zero fill
    input  wire logic [((9*COORD_BITS+7)/8)*8-1:0]     s_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    // norm_x, norm_y, norm_z
    output logic [3*tun_pkg::NORM_BITS-1:0]            m_tdata,
    // degenerate
    output logic                                       m_tuser
);
    localparam int QB  = tun_pkg::NORM_BITS;
    localparam int XW  = 2 * COORD_BITS + 2;
    localparam int M2W = 4 * COORD_BITS + 2;
    localparam int SW  = M2W + 2;
    localparam int RW  = M2W + tun_pkg::FRAC_SHIFT;
    localparam int QSW = SW + QB;
    localparam int NL  = tun_pkg::LANES;
    localparam int NST = QB;

    logic signed [XW-1:0] cr_c [NL];
    logic                 cr_valid, cr_ready;
    logic [M2W-1:0]       sq_m2 [NL];
    logic [SW-1:0]        sq_s;
    logic [NL-1:0]        sq_neg;
    logic                 sq_degen;
    logic                 sq_valid;

    logic [RW-1:0]        st_r     [NST+1][NL];
    logic [QSW-1:0]       st_qs    [NST+1][NL];
    logic [QB-1:0]        st_q     [NST+1][NL];
    logic [SW-1:0]        st_s     [NST+1];
    logic [NL-1:0]        st_neg   [NST+1];
    logic                 st_degen [NST+1];
    logic                 st_v     [NST+1];
    logic                 st_rdy   [NST+1];

    logic [QB-1:0]        norm_next [NL];
    logic [QB-1:0]        norm_reg  [NL];
    logic                 degen_reg;
    logic                 out_v_reg;
    logic                 out_en;

    tun_cross #(.COORD_BITS(COORD_BITS)) u_cross (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_vtx    (s_tdata[9*COORD_BITS-1:0]),
        .out_valid (cr_valid),
        .out_ready (cr_ready),
        .out_c     (cr_c)
    );

    tun_square #(.COORD_BITS(COORD_BITS)) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cr_valid),
        .in_ready  (cr_ready),
        .in_c      (cr_c),
        .out_valid (sq_valid),
        .out_ready (st_rdy[0]),
        .out_m2    (sq_m2),
        .out_s     (sq_s),
        .out_neg   (sq_neg),
        .out_degen (sq_degen)
    );

    // search starts with remainder c^2 * 2^30 and an empty quotient
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            st_r[0][i]  = RW'(sq_m2[i]) << tun_pkg::FRAC_SHIFT;
            st_qs[0][i] = '0;
            st_q[0][i]  = '0;
        end
    end
    assign st_s[0]     = sq_s;
    assign st_neg[0]   = sq_neg;
    assign st_degen[0] = sq_degen;
    assign st_v[0]     = sq_valid;

    for (genvar k = 0; k < NST; k++)
    begin : g_root
        tun_root_step #(.COORD_BITS(COORD_BITS), .BIT(NST - 1 - k)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (st_v[k]),
            .in_ready  (st_rdy[k]),
            .in_r      (st_r[k]),
            .in_qs     (st_qs[k]),
            .in_q      (st_q[k]),
            .in_s      (st_s[k]),
            .in_neg    (st_neg[k]),
            .in_degen  (st_degen[k]),
            .out_valid (st_v[k+1]),
            .out_ready (st_rdy[k+1]),
            .out_r     (st_r[k+1]),
            .out_qs    (st_qs[k+1]),
            .out_q     (st_q[k+1]),
            .out_s     (st_s[k+1]),
            .out_neg   (st_neg[k+1]),
            .out_degen (st_degen[k+1])
        );
    end

    assign out_en      = !out_v_reg || m_tready;
    assign st_rdy[NST] = out_en;

    // apply sign, hold positive full scale at the top code, zero a degenerate
    always_comb
    begin
        for (int i = 0; i < NL; i++)
        begin
            if (st_degen[NST])
            begin
                norm_next[i] = '0;
            end
            else if (st_neg[NST][i])
            begin
                norm_next[i] = QB'(0) - st_q[NST][i];
            end
            else if (st_q[NST][i] > tun_pkg::NORM_MAX)
            begin
                norm_next[i] = tun_pkg::NORM_MAX;
            end
            else
            begin
                norm_next[i] = st_q[NST][i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_v_reg <= st_v[NST];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            norm_reg  <= norm_next;
            degen_reg <= st_degen[NST];
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {norm_reg[2], norm_reg[1], norm_reg[0]};
    assign m_tuser  = degen_reg;

endmodule
`default_nettype wire

// ----- test/triangle_unit_normal_tb.sv -----
`default_nettype none
class normal_scoreboard;
    typedef struct packed {
        logic [15:0] nz;
        logic [15:0] ny;
        logic [15:0] nx;
        logic        degen;
    } normal_t;

    normal_t pending_normals[$];
    int      errors;

    function new();
        errors = 0;
    endfunction

    // largest q with q*q*S <= c*c*2^30, sign applied, positive full scale held
    function logic [15:0] unit_component(longint c, logic [127:0] sum_sq);
        logic [127:0] mag;
        logic [127:0] limit;
        logic [127:0] trial;
        logic [16:0]  q;
        logic [16:0]  t;
        mag = (c < 0) ? -c : c;
        limit = (mag * mag) << 30;
        q = 0;
        for (int b = 15; b >= 0; b--)
        begin
            t = q | (17'd1 << b);
            trial = {111'd0, t} * {111'd0, t} * sum_sq;
            if (trial <= limit)
                q = t;
        end
        if (c < 0)
            return 16'(17'h10000 - q);
        if (q > 32767)
            q = 32767;
        return q[15:0];
    endfunction

    function void note_triangle(logic [143:0] beat);
        longint       p[9];
        longint       ea[3];
        longint       eb[3];
        longint       cr[3];
        logic [127:0] sum_sq;
        logic [127:0] m;
        normal_t      res;
        for (int i = 0; i < 9; i++)
            p[i] = longint'($signed(beat[16*i +: 16]));
        for (int i = 0; i < 3; i++)
        begin
            ea[i] = p[3 + i] - p[i];
            eb[i] = p[6 + i] - p[i];
        end
        cr[0] = ea[1] * eb[2] - ea[2] * eb[1];
        cr[1] = ea[2] * eb[0] - ea[0] * eb[2];
        cr[2] = ea[0] * eb[1] - ea[1] * eb[0];
        if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0)
        begin
            res = '{16'd0, 16'd0, 16'd0, 1'b1};
        end
        else
        begin
            sum_sq = 0;
            for (int i = 0; i < 3; i++)
            begin
                m = (cr[i] < 0) ? -cr[i] : cr[i];
                sum_sq += m * m;
            end
            res.nx = unit_component(cr[0], sum_sq);
            res.ny = unit_component(cr[1], sum_sq);
            res.nz = unit_component(cr[2], sum_sq);
            res.degen = 1'b0;
        end
        pending_normals.push_back(res);
    endfunction

    function void check_normal(logic [47:0] data, logic degen);
        normal_t e;
        if (pending_normals.size() == 0)
        begin
            $display("%0t: unexpected beat, actual %h/%b", $time, data, degen);
            errors++;
            return;
        end
        e = pending_normals.pop_front();
        if (data[15:0] !== e.nx)
        begin
            $display("%0t: norm_x expected %h actual %h", $time, e.nx, data[15:0]);
            errors++;
        end
        if (data[31:16] !== e.ny)
        begin
            $display("%0t: norm_y expected %h actual %h", $time, e.ny, data[31:16]);
            errors++;
        end
        if (data[47:32] !== e.nz)
        begin
            $display("%0t: norm_z expected %h actual %h", $time, e.nz, data[47:32]);
            errors++;
        end
        if (degen !== e.degen)
        begin
            $display("%0t: degenerate expected %b actual %b", $time, e.degen, degen);
            errors++;
        end
    endfunction
endclass

module triangle_unit_normal_tb;
    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [143:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [47:0]  m_tdata;
    logic         m_tuser;

    normal_scoreboard sb;
    int  idle_cycles;
    bit  burst_tx;
    bit  burst_rx;

    triangle_unit_normal DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        sb = new();
        rst_n = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1;
    end

    always @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            sb.note_triangle(s_tdata);
        if (m_tvalid && m_tready)
            sb.check_normal(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 3000)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // receiver: random hold-off before each beat, with no-stall stretches
    initial
    begin
        int n;
        m_tready = 0;
        @(posedge rst_n);
        forever
        begin
            if ($urandom_range(0, 40) == 0)
                burst_rx = !burst_rx;
            n = burst_rx ? 0 : $urandom_range(0, 12);
            if (n > 0)
            begin
                m_tready <= 0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1;
            do @(posedge clk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic send_triangle(logic [143:0] tri_data);
        int n;
        if ($urandom_range(0, 40) == 0)
            burst_tx = !burst_tx;
        n = burst_tx ? 0 : $urandom_range(0, 12);
        if (n > 0)
        begin
            s_tvalid <= 0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1;
        s_tdata <= tri_data;
        do @(posedge clk); while (!(s_tvalid && s_tready));
    endtask

    function automatic logic [143:0] pack_tri(int c[9]);
        logic [143:0] r;
        for (int i = 0; i < 9; i++)
            r[16*i +: 16] = 16'(c[i]);
        return r;
    endfunction

    task automatic drain();
        s_tvalid <= 0;
        while (sb.pending_normals.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        int c[9];
        int k;
        int span;
        s_tvalid = 0;
        s_tdata = '0;
        @(posedge rst_n);
        @(posedge clk);
        // all-zero and collinear: degenerate
        send_triangle(pack_tri('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
        send_triangle(pack_tri('{1, 2, 3, 2, 4, 6, 3, 6, 9}));
        send_triangle(pack_tri('{-32768, -32768, -32768, 32767, 32767, 32767,
                                 0, 0, 0}));
        // axis-aligned normals: full positive scale held at 32767, negative -32768
        send_triangle(pack_tri('{0, 0, 0, 1, 0, 0, 0, 1, 0}));
        send_triangle(pack_tri('{0, 0, 0, 0, 1, 0, 1, 0, 0}));
        send_triangle(pack_tri('{0, 0, 0, 0, 1, 0, 0, 0, 1}));
        send_triangle(pack_tri('{0, 0, 0, 0, 0, 1, 0, 1, 0}));
        send_triangle(pack_tri('{0, 0, 0, 0, 0, 1, 1, 0, 0}));
        send_triangle(pack_tri('{0, 0, 0, 1, 0, 0, 0, 0, 1}));
        // largest cross products, then a small one and a repeated vertex (degenerate)
        send_triangle(pack_tri('{-32768, -32768, -32768, 32767, -32768, -32768,
                                 -32768, 32767, -32768}));
        send_triangle(pack_tri('{32767, 32767, 32767, -32768, 32767, 32767,
                                 32767, -32768, 32767}));
        send_triangle(pack_tri('{-32768, 32767, -32768, 32767, -32768, 32767,
                                 -32768, -32768, 32767}));
        send_triangle(pack_tri('{32767, -32768, 0, -32768, 32767, 32767,
                                 0, -32768, -32768}));
        send_triangle(pack_tri('{0, 0, 0, 1, 1, 1, 1, -1, 0}));
        send_triangle(pack_tri('{5, -7, 3, 5, -7, 3, 9, 9, 9}));
        drain();
        for (int it = 0; it < 1350; it++)
        begin
            k = $urandom_range(0, 9);
            span = (k < 4) ? 65535 : (k < 7) ? $urandom_range(1, 300) : 3;
            for (int i = 0; i < 9; i++)
                c[i] = (span == 65535) ? int'($urandom) & 16'hFFFF
                                       : $urandom_range(0, 2 * span) - span;
            if (k == 9)
                for (int i = 0; i < 3; i++)
                    c[6 + i] = 2 * c[3 + i] - c[i];
            send_triangle(pack_tri(c));
        end
        s_tvalid <= 0;
        while (sb.pending_normals.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
